@@ rtl/r250_pkg.sv @@
package r250_pkg;

    localparam int TABLE_DEPTH = 250;
    localparam int ADDR_W      = 8;
    localparam int WORD_W      = 16;
    localparam int DIV_W       = 17;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = 5;
    localparam int DIAG_COUNT  = 16;
    localparam int DIAG_W      = 4;

    localparam logic [ADDR_W-1:0]    LAST_ADDR   = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W:0]      LAG_AHEAD   = 9'd103;
    localparam logic [ADDR_W:0]      DEPTH_WIDE  = 9'(TABLE_DEPTH);
    localparam logic [31:0]          LCG_MULT    = 32'h015a4e35;
    localparam logic [14:0]          FLAG_LIMIT  = 15'd16384;
    localparam logic [WORD_W-1:0]    WORD_ONES   = 16'hffff;
    localparam logic [WORD_W-1:0]    WORD_TOP    = 16'h8000;
    localparam logic [DIV_W-1:0]     RAND_RANGE  = 17'h10000;
    localparam logic [ADDR_W-1:0]    DIAG_START  = 8'd3;
    localparam logic [ADDR_W-1:0]    DIAG_STEP   = 8'd11;
    localparam logic [DIAG_W-1:0]    DIAG_LAST   = DIAG_W'(DIAG_COUNT - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [1:0] FUNC_RAW     = 2'd0;
    localparam logic [1:0] FUNC_BOUNDED = 2'd1;
    localparam logic [1:0] FUNC_RESEED  = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DIV_LIM = 9'b000000010,
        ST_DRAW    = 9'b000000100,
        ST_DIV_MOD = 9'b000001000,
        ST_EMIT    = 9'b000010000,
        ST_FILL    = 9'b000100000,
        ST_MARK    = 9'b001000000,
        ST_DIAG    = 9'b010000000,
        ST_FLUSH   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    localparam logic [WORD_W-1:0] SEED_WORDS [TABLE_DEPTH] = '{
        15301, 57764, 10921, 56345, 19316, 43154, 54727, 49252, 32360, 49582,
        26124, 25833, 34404, 11030, 26232, 13965, 16051, 63635, 55860,  5184,
        15931, 39782, 16845, 11371, 38624, 10328,  9139,  1684, 48668, 59388,
        13297,  1364, 56028, 15687, 63279, 27771,  5277, 44628, 31973, 46977,
        16327, 23408, 36065, 52272, 33610, 61549, 58364,  3472, 21367, 56357,
        56345, 54035,  7712, 55884, 39774, 10241, 50164, 47995,  1718, 46887,
        47892,  6010, 29575, 54972, 30458, 21966, 54449, 10387,  4492,   644,
        57031, 41607, 61820, 54588, 40849, 54052, 59875, 43128, 50370, 44691,
          286, 12071,  3574, 61384, 15592, 45677,  9711, 23022, 35256, 45493,
        48913,   146,  9053,  5881, 36635, 43280, 53464,  8529, 34344, 64955,
        38266, 12730,   101, 16208, 12607, 58921, 22036,  8221, 31337, 11984,
        20290, 26734, 19552,    48, 31940, 43448, 34762, 53344, 60664, 12809,
        57318, 17436, 44730, 19375,    30, 17425, 14117,  5416, 23853, 55783,
        57995, 32074, 26526,  2192, 11447,    11, 53446, 35152, 64610, 64883,
        26899, 25357,  7667,  3577, 39414, 51161,     4, 58427, 57342, 58557,
        53233,  1066, 29237, 36808, 19370, 17493, 37568,     3, 61468, 38876,
        17586, 64937, 21716, 56472, 58160, 44955, 55221, 63880,     1, 32200,
        62066, 22911, 24090, 10438, 40783, 36364, 14999,  2489, 43284,  9898,
        39612,  9245,   593, 34857, 41054, 30162, 65497, 53340, 27209, 45417,
        37497,  4612, 58397, 52910, 56313, 62716, 22377, 40310, 15190, 34471,
        64005, 18090, 11326, 50839, 62901, 59284,  5580, 15231,  9467, 13161,
        58500,  7259,   317, 50968,  2962, 23006, 32280,  6994, 18751,  5148,
        52739, 49370, 51892, 18552, 52264, 54031,  2804, 17360,  1919, 19639,
         2323,  9448, 43821, 11022, 45500, 31509, 49180, 35598, 38883, 19754,
          987, 11521, 55494, 38056, 20664,  2629, 50986, 31009, 54043, 59743
    };

endpackage

@@ rtl/r250_mem.sv @@
module r250_mem import r250_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_wr_t           wr,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0]      lag_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [WORD_W-1:0]      ram_a_reg;
    logic [WORD_W-1:0]      ram_b_reg;
    logic [WORD_W-1:0]      seed_a_reg;
    logic [WORD_W-1:0]      seed_b_reg;
    logic                   vld_a_reg;
    logic                   vld_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            lag_mem[wr.addr] <= wr.data;
        end
        ram_a_reg  <= lag_mem[rd_addr_a];
        ram_b_reg  <= lag_mem[rd_addr_b];
        seed_a_reg <= SEED_WORDS[rd_addr_a];
        seed_b_reg <= SEED_WORDS[rd_addr_b];
        vld_a_reg  <= vld_reg[rd_addr_a];
        vld_b_reg  <= vld_reg[rd_addr_b];
    end

    // unwritten entries still hold their power-on seed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data_a = vld_a_reg ? ram_a_reg : seed_a_reg;
    assign rd_data_b = vld_b_reg ? ram_b_reg : seed_b_reg;

endmodule

@@ rtl/r250_div.sv @@
module r250_div import r250_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       trial;
    logic                 fits;
    logic [DIV_W-1:0]     rem_step;

    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_step = fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_reg <= DIV_CNT_W'(cnt_reg + 1'b1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) rsp.done |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

@@ rtl/r250_random_generator.sv @@
// channel | ports             | tdata bits (low first)            | tuser
// input   | s_tvalid/s_tready | seed_value[31:0], bound[48:32]    | func[1:0]
// result  | m_tvalid/m_tready | value[15:0]                       | -
// One item at a time. A raw draw reads both lag taps, then XORs them and writes
// the result back. A bounded draw makes two draws per attempt plus two passes
// of the 17-step serial divider.
// A reseed makes 250 fill writes, 250 read-modify-writes and 16 diagonal
// updates, then passes through a flush state.
// Reset restores the seed table through per-entry valid bits.
// A stalled result sits in the output register; the next result waits in a
// holding register and the input stops.
module r250_random_generator import r250_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // seed_value[31:0], bound[48:32], zero [55:49]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // value[15:0]
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [1:0]          func_reg, func_next;
    logic [DIV_W-1:0]    bound_reg, bound_next;
    logic [DIV_W-1:0]    limit_reg, limit_next;
    logic                phase_reg, phase_next;
    logic [WORD_W-1:0]   res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [DIAG_W-1:0]   diag_cnt_reg, diag_cnt_next;
    logic [ADDR_W-1:0]   diag_addr_reg, diag_addr_next;
    logic [31:0]         lcg_reg, lcg_next;
    logic                p_vld_reg, p_vld_next;
    logic [ADDR_W-1:0]   p_addr_reg, p_addr_next;
    logic                p_mark_reg, p_mark_next;
    logic                p_flag_reg, p_flag_next;
    logic [DIAG_W-1:0]   p_j_reg, p_j_next;

    logic [1:0]          in_func;
    logic [31:0]         in_seed;
    logic [DIV_W-1:0]    in_bound;
    logic [DIV_W-1:0]    bound_clamp;
    logic                s_accept;
    logic                out_free;
    logic [ADDR_W-1:0]   ptr_step;
    logic [ADDR_W:0]     ahead_sum;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [WORD_W-1:0]   rd_a;
    logic [WORD_W-1:0]   rd_b;
    logic [WORD_W-1:0]   draw_word;
    logic [WORD_W-1:0]   rmw_data;
    logic [31:0]         lcg_step;
    mem_wr_t             wr;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign in_func     = s_tuser;
    assign in_seed     = s_tdata[31:0];
    assign in_bound    = s_tdata[48:32];
    assign bound_clamp = (in_bound == '0 || (in_bound[DIV_W-1] && |in_bound[DIV_W-2:0]))
                         ? RAND_RANGE : in_bound;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign ptr_step  = (ptr_reg == LAST_ADDR) ? '0 : ADDR_W'(ptr_reg + 1'b1);
    assign draw_word = rd_a ^ rd_b;
    assign lcg_step  = 32'(lcg_reg * LCG_MULT) + 32'd1;
    assign rmw_data  = p_mark_reg ? {rd_a[WORD_W-1] | p_flag_reg, rd_a[WORD_W-2:0]}
                                  : ((rd_a & (WORD_ONES >> p_j_reg)) | (WORD_TOP >> p_j_reg));

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        func_next      = func_reg;
        bound_next     = bound_reg;
        limit_next     = limit_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        cnt_next       = cnt_reg;
        diag_cnt_next  = diag_cnt_reg;
        diag_addr_next = diag_addr_reg;
        lcg_next       = lcg_reg;
        p_vld_next     = 1'b0;
        p_addr_next    = p_addr_reg;
        p_mark_next    = p_mark_reg;
        p_flag_next    = p_flag_reg;
        p_j_next       = p_j_reg;
        wr             = '0;
        div_req        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    func_next = in_func;
                    case (in_func)
                        FUNC_RAW: begin
                            state_next = ST_DRAW;
                        end
                        FUNC_BOUNDED: begin
                            bound_next       = bound_clamp;
                            phase_next       = 1'b0;
                            div_req.start    = 1'b1;
                            div_req.dividend = RAND_RANGE;
                            div_req.divisor  = bound_clamp;
                            state_next       = ST_DIV_LIM;
                        end
                        FUNC_RESEED: begin
                            ptr_next   = '0;
                            lcg_next   = in_seed;
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV_LIM: begin
                if (div_rsp.done) begin
                    limit_next = DIV_W'(RAND_RANGE - div_rsp.rem);
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                wr.en    = 1'b1;
                wr.addr  = ptr_reg;
                wr.data  = draw_word;
                ptr_next = ptr_step;
                if (func_reg == FUNC_RAW) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = draw_word;
                        state_next    = ST_IDLE;
                    end else begin
                        res_next   = draw_word;
                        state_next = ST_EMIT;
                    end
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    phase_next = 1'b0;
                    if ({1'b0, draw_word} < limit_reg) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, draw_word};
                        div_req.divisor  = bound_reg;
                        state_next       = ST_DIV_MOD;
                    end
                end
            end
            ST_DIV_MOD: begin
                if (div_rsp.done) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = div_rsp.rem[WORD_W-1:0];
                        state_next    = ST_IDLE;
                    end else begin
                        res_next   = div_rsp.rem[WORD_W-1:0];
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_FILL: begin
                lcg_next = lcg_step;
                wr.en    = 1'b1;
                wr.addr  = cnt_reg;
                wr.data  = {1'b0, lcg_step[30:16]};
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_MARK;
                end else begin
                    cnt_next = ADDR_W'(cnt_reg + 1'b1);
                end
            end
            ST_MARK: begin
                lcg_next    = lcg_step;
                p_vld_next  = 1'b1;
                p_addr_next = cnt_reg;
                p_mark_next = 1'b1;
                p_flag_next = lcg_step[30:16] > FLAG_LIMIT;
                if (cnt_reg == LAST_ADDR) begin
                    diag_cnt_next  = '0;
                    diag_addr_next = DIAG_START;
                    state_next     = ST_DIAG;
                end else begin
                    cnt_next = ADDR_W'(cnt_reg + 1'b1);
                end
            end
            ST_DIAG: begin
                p_vld_next     = 1'b1;
                p_addr_next    = diag_addr_reg;
                p_mark_next    = 1'b0;
                p_j_next       = diag_cnt_reg;
                diag_addr_next = ADDR_W'(diag_addr_reg + DIAG_STEP);
                if (diag_cnt_reg == DIAG_LAST) begin
                    state_next = ST_FLUSH;
                end else begin
                    diag_cnt_next = DIAG_W'(diag_cnt_reg + 1'b1);
                end
            end
            ST_FLUSH: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // finish the read-modify-write issued in the cycle before
        if (p_vld_reg) begin
            wr.en   = 1'b1;
            wr.addr = p_addr_reg;
            wr.data = rmw_data;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_MARK: rd_addr_a = cnt_reg;
            ST_DIAG: rd_addr_a = diag_addr_reg;
            default: rd_addr_a = ptr_next;
        endcase
    end

    assign ahead_sum = {1'b0, ptr_next} + LAG_AHEAD;
    assign rd_addr_b = (ahead_sum >= DEPTH_WIDE) ? ADDR_W'(ahead_sum - DEPTH_WIDE)
                                                 : ahead_sum[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            p_vld_reg    <= 1'b0;
            lcg_reg      <= 32'd1;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
            p_vld_reg    <= p_vld_next;
            lcg_reg      <= lcg_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        bound_reg     <= bound_next;
        limit_reg     <= limit_next;
        res_reg       <= res_next;
        m_tdata_reg   <= m_tdata_next;
        cnt_reg       <= cnt_next;
        diag_cnt_reg  <= diag_cnt_next;
        diag_addr_reg <= diag_addr_next;
        p_addr_reg    <= p_addr_next;
        p_mark_reg    <= p_mark_next;
        p_flag_reg    <= p_flag_next;
        p_j_reg       <= p_j_next;
    end

    r250_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    r250_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assert property (@(posedge aclk) disable iff (!aresetn) ptr_reg <= LAST_ADDR)
        else $error("draw pointer out of table");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_LIM || state_reg == ST_DIV_MOD))
        else $error("divider result with no waiting state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW && func_reg == FUNC_BOUNDED)
        |-> (limit_reg >= bound_reg && limit_reg != '0))
        else $error("rejection limit below bound");

endmodule

@@ bench/tb_r250_random_generator.sv @@
module tb_r250_random_generator import r250_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 9;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 600;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CALM_ITEMS  = 300;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
    logic [ADDR_W-1:0] draw_ptr;
    logic [31:0]       lcg_state;

    logic [15:0] expected_words [$];
    logic [15:0] want_word;
    int          err_count;
    int          cycle_count;
    bit          idle_on;
    int          hold_ticket;
    int          hold_seen;
    int          rx_gap;

    r250_random_generator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // advance the lag table by one word
    function automatic logic [15:0] lag_draw();
        int          here;
        int          ahead;
        logic [15:0] w;
        here  = int'(draw_ptr) % TABLE_DEPTH;
        ahead = (here + int'(LAG_AHEAD)) % TABLE_DEPTH;
        w = lag_words[here] ^ lag_words[ahead];
        lag_words[here] = w;
        if (draw_ptr >= LAST_ADDR) begin
            draw_ptr = '0;
        end else begin
            draw_ptr = draw_ptr + 1'b1;
        end
        return w;
    endfunction

    function automatic logic [14:0] lcg_advance();
        lcg_state = lcg_state * LCG_MULT + 32'd1;
        return lcg_state[30:16];
    endfunction

    function automatic void lag_reseed(logic [31:0] seed);
        logic [15:0] keep;
        logic [15:0] top;
        int          k;
        keep = WORD_ONES;
        top  = WORD_TOP;
        draw_ptr  = '0;
        lcg_state = seed;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            lag_words[j] = {1'b0, lcg_advance()};
        end
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (lcg_advance() > FLAG_LIMIT) begin
                lag_words[j] = lag_words[j] | WORD_TOP;
            end
        end
        for (int j = 0; j < DIAG_COUNT; j++) begin
            k = (11 * j + 3) % TABLE_DEPTH;
            lag_words[k] = (lag_words[k] & keep) | top;
            keep = keep >> 1;
            top  = top >> 1;
        end
    endfunction

    function automatic logic [15:0] bounded_draw(logic [16:0] bound);
        int          n;
        int          limit;
        logic [15:0] w;
        n = int'(bound);
        if (n == 0 || n > int'(RAND_RANGE)) begin
            n = int'(RAND_RANGE);
        end
        limit = (int'(RAND_RANGE) / n) * n;
        do begin
            w = lag_draw();
            w = lag_draw();
        end while (int'(w) >= limit);
        return 16'(int'(w) % n);
    endfunction

    function automatic void predict_item(logic [1:0] func, logic [31:0] seed,
                                         logic [16:0] bound);
        case (func)
            FUNC_RAW: begin
                expected_words.push_back(lag_draw());
            end
            FUNC_BOUNDED: begin
                expected_words.push_back(bounded_draw(bound));
            end
            FUNC_RESEED: begin
                lag_reseed(seed);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic note_failure(string what, logic [15:0] want, logic [15:0] got);
        err_count++;
        if (err_count <= 10) begin
            $display("%s: expected %h, got %h", what, want, got);
        end
    endtask

    task automatic send_item(logic [1:0] func, logic [31:0] seed, logic [16:0] bound);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, bound, seed};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(func, seed, bound);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [16:0] pick_bound();
        case ($urandom_range(0, 5))
            0: return 17'($urandom_range(1, 16));
            1: return 17'($urandom_range(1, 65536));
            2: return 17'($urandom_range(32768, 65536));
            3: return 17'($urandom);
            4: return 17'($urandom_range(1, 1024));
            default: return 17'($urandom_range(65530, 65536));
        endcase
    endfunction

    task automatic test_seed_table();
        repeat (4) send_item(FUNC_RAW, 32'h0, 17'h0);
    endtask

    task automatic test_bound_extremes();
        send_item(FUNC_BOUNDED, 32'h0, 17'd1);
        send_item(FUNC_BOUNDED, 32'h0, 17'd2);
        send_item(FUNC_BOUNDED, 32'h0, 17'd3);
        send_item(FUNC_BOUNDED, 32'h0, 17'd32769);
        send_item(FUNC_BOUNDED, 32'h0, 17'd65535);
        send_item(FUNC_BOUNDED, 32'h0, 17'd65536);
        send_item(FUNC_BOUNDED, 32'h0, 17'd0);
        send_item(FUNC_BOUNDED, 32'h0, 17'd65537);
        send_item(FUNC_BOUNDED, 32'hffffffff, 17'h1ffff);
    endtask

    task automatic test_reseed_extremes();
        send_item(FUNC_RESEED, 32'h0, 17'h1ffff);
        send_item(FUNC_RAW, 32'hffffffff, 17'h1ffff);
        send_item(FUNC_RAW, 32'h0, 17'h0);
        send_item(FUNC_RESEED, 32'hffffffff, 17'h0);
        send_item(FUNC_RAW, 32'h0, 17'h0);
        send_item(FUNC_UNUSED, 32'h12345678, 17'd77);
        send_item(FUNC_BOUNDED, 32'h0, 17'd10);
    endtask

    task automatic test_output_backpressure();
        hold_ticket <= hold_ticket + 1;
        repeat (12) send_item(FUNC_RAW, $urandom, 17'($urandom));
        send_item(FUNC_BOUNDED, $urandom, 17'd1000);
    endtask

    task automatic test_sender_pause();
        repeat (6) send_item(FUNC_BOUNDED, $urandom, pick_bound());
        wait_drained();
        repeat (6) send_item(FUNC_RAW, $urandom, 17'($urandom));
    endtask

    task automatic test_random_mix();
        int         counted;
        int         pick;
        logic [1:0] func;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_on = (counted < RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 54) begin
                func = FUNC_RAW;
            end else if (pick < 95) begin
                func = FUNC_BOUNDED;
            end else if (pick < 98) begin
                func = FUNC_RESEED;
            end else begin
                func = FUNC_UNUSED;
            end
            send_item(func, $urandom, pick_bound());
            if (func != FUNC_UNUSED) begin
                counted++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_gap    <= 0;
            hold_seen <= hold_ticket;
        end else if (hold_seen != hold_ticket) begin
            hold_seen <= hold_ticket;
            rx_gap    <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_gap   <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                note_failure("unexpected result", 16'h0, m_tdata);
            end else begin
                want_word = expected_words.pop_front();
                if (m_tdata !== want_word) begin
                    note_failure("value mismatch", want_word, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        idle_on     = 1'b1;
        hold_ticket = 0;
        lag_words   = SEED_WORDS;
        draw_ptr    = '0;
        lcg_state   = 32'd1;
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_seed_table();
        test_bound_extremes();
        test_reseed_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_mix();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/r250_pkg.sv
rtl/r250_mem.sv
rtl/r250_div.sv
rtl/r250_random_generator.sv
bench/tb_r250_random_generator.sv
